>>> hw/rtl/spbq_pkg.sv
// spbq_pkg: shared defaults and result/opcode codes for the strict priority batch queue
// no dependencies; imported by strict_priority_batch_queue and spbq_checker
package spbq_pkg;

    // parameter defaults
    localparam int RING_SLOTS_DEF = 8;
    localparam int LEVELS_DEF     = 4;
    localparam int BATCH_MAX_DEF  = 4;
    localparam int WORD_BITS_DEF  = 32;

    // saturation value of the batch counter
    localparam int CNT_W           = 8;
    localparam logic [CNT_W-1:0] CNT_SAT = 8'hFF;

    // input opcodes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_WORD  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // control sequencer, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } t_state;

endpackage

>>> hw/rtl/strict_priority_batch_queue.sv
// strict_priority_batch_queue: LEVELS circular rings in one slot memory, strict priority dequeue
// depends on spbq_pkg
//
// usage:
//   input channel (i_in_valid / o_in_stall) carries enqueue or dequeue requests;
//   output channel (o_out_valid / i_out_stall) carries results, each one transfer.
//   an enqueue gives one ack result; once it is taken, its ack sits in the
//   output register the next cycle. a dequeue that finds nothing (all rings empty or
//   take_limit zero) also gives one result, registered the same way.
//   a dequeue that takes n words (n up to BATCH_MAX) does the priority search while
//   idle and then, per word, reads the slot memory (one read port, registered read)
//   and loads the word into the output register; a stall can hold that load.
//   the block works on one request at a time; the next request is taken once the
//   last result of the current one sits in the output register.
//   a stall from the receiver holds the output register and holds the sequencer in
//   S_OUT; the input side is stalled while the output register cannot be loaded.
//   reset (synchronous, active low) empties every ring, clears the batch counter and
//   drops o_out_valid. the slot memory is not cleared; a slot is read only after
//   it has been written.
module strict_priority_batch_queue
    import spbq_pkg::*;
#(
    parameter int RING_SLOTS = RING_SLOTS_DEF,
    parameter int LEVELS     = LEVELS_DEF,
    parameter int BATCH_MAX  = BATCH_MAX_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF,
    localparam int PTR_W     = $clog2(RING_SLOTS),
    localparam int LVL_W     = $clog2(LEVELS),
    localparam int MAXI_W    = $clog2(BATCH_MAX + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_opcode,
    input  logic [LVL_W-1:0]     i_priority_req,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic                 i_batch_end,
    input  logic [MAXI_W-1:0]    i_take_limit,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_kind,
    output logic                 o_accepted,
    output logic [CNT_W-1:0]     o_added_count,
    output logic [WORD_BITS-1:0] o_out_value,
    output logic [LVL_W-1:0]     o_out_priority,
    output logic                 o_last
);

    localparam int ADDR_W = LVL_W + PTR_W;
    localparam int DEPTH  = 1 << ADDR_W;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(RING_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    // slot memory
    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;

    // control and pointer state
    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_rp [LEVELS];
    logic [PTR_W-1:0]  n_rp [LEVELS];
    logic [PTR_W-1:0]  r_wp [LEVELS];
    logic [PTR_W-1:0]  n_wp [LEVELS];
    logic [CNT_W-1:0]  r_batch, n_batch;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [MAXI_W-1:0] r_left, n_left;
    logic              r_last_word, n_last_word;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_kind, n_kind;
    logic                 r_accepted, n_accepted;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [WORD_BITS-1:0] r_val, n_val;
    logic [LVL_W-1:0]     r_pri, n_pri;
    logic                 r_last, n_last;

    // memory access controls
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_wa, mem_ra;

    logic              out_free, in_xfer;
    logic [LVL_W-1:0]  p_idx;
    logic [PTR_W-1:0]  p_rp, p_wp, p_nxt;
    logic              lvl_ok;
    logic [LEVELS-1:0] nonempty;
    logic              found;
    logic [LVL_W-1:0]  found_lvl;
    logic [MAXI_W-1:0] maxi_clamp;
    logic              enq_ok;
    logic [CNT_W-1:0]  cnt_after;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // one pointer read port: request level while idle, else the level being drained
    assign p_idx = (r_state == S_IDLE) ? i_priority_req : r_lvl;
    assign p_rp  = r_rp[p_idx];
    assign p_wp  = r_wp[p_idx];
    assign p_nxt = (r_state == S_IDLE) ? ring_next(p_wp) : ring_next(p_rp);

    assign lvl_ok = ({1'b0, i_priority_req} < (LVL_W + 1)'(LEVELS));

    // per-ring empty flags and strict priority search
    always_comb begin
        found     = 1'b0;
        found_lvl = '0;
        for (int i = 0; i < LEVELS; i++) begin
            nonempty[i] = (r_rp[i] != r_wp[i]);
        end
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (nonempty[i]) begin
                found     = 1'b1;
                found_lvl = LVL_W'(i);
            end
        end
    end

    assign maxi_clamp = (i_take_limit > MAXI_W'(BATCH_MAX)) ? MAXI_W'(BATCH_MAX) : i_take_limit;
    assign enq_ok     = lvl_ok && (p_nxt != p_rp);
    assign cnt_after  = (enq_ok && r_batch != CNT_SAT) ? r_batch + 1'b1 : r_batch;

    // sequencer and next-state logic; enqueue writes only while idle and reads
    // only happen while draining, so no two accesses to one slot overlap
    always_comb begin
        n_state     = r_state;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_batch     = r_batch;
        n_lvl       = r_lvl;
        n_left      = r_left;
        n_last_word = r_last_word;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_accepted  = r_accepted;
        n_cnt       = r_cnt;
        n_val       = r_val;
        n_pri       = r_pri;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wa      = {i_priority_req, p_wp};
        mem_ra      = {r_lvl, p_rp};

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_opcode == OP_ENQ) begin
                        if (enq_ok) begin
                            mem_we             = 1'b1;
                            n_wp[i_priority_req] = p_nxt;
                        end
                        n_batch     = i_batch_end ? '0 : cnt_after;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_ACK;
                        n_accepted  = enq_ok;
                        n_cnt       = cnt_after;
                        n_val       = '0;
                        n_pri       = '0;
                        n_last      = 1'b1;
                    end else if (!found || maxi_clamp == '0) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_EMPTY;
                        n_accepted  = 1'b0;
                        n_cnt       = '0;
                        n_val       = '0;
                        n_pri       = '0;
                        n_last      = 1'b1;
                    end else begin
                        n_lvl   = found_lvl;
                        n_left  = maxi_clamp;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                mem_re        = 1'b1;
                n_rp[r_lvl]   = p_nxt;
                n_left        = r_left - 1'b1;
                n_last_word   = (r_left == MAXI_W'(1)) || (p_nxt == p_wp);
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_WORD;
                    n_accepted  = 1'b0;
                    n_cnt       = '0;
                    n_val       = r_rd_data;
                    n_pri       = r_lvl;
                    n_last      = r_last_word;
                    n_state     = r_last_word ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= i_value;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_batch     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                r_rp[i] <= '0;
                r_wp[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_batch     <= n_batch;
            r_out_valid <= n_out_valid;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lvl       <= n_lvl;
        r_left      <= n_left;
        r_last_word <= n_last_word;
        r_kind      <= n_kind;
        r_accepted  <= n_accepted;
        r_cnt       <= n_cnt;
        r_val       <= n_val;
        r_pri       <= n_pri;
        r_last      <= n_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_accepted     = r_accepted;
    assign o_added_count  = r_cnt;
    assign o_out_value    = r_val;
    assign o_out_priority = r_pri;
    assign o_last         = r_last;

endmodule

>>> hw/rtl/spbq_checker.sv
// spbq_checker: port-level assertions for strict_priority_batch_queue, plus its bind
// depends on spbq_pkg and strict_priority_batch_queue
module spbq_checker
    import spbq_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int LVL_W     = 2
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [1:0]           o_kind,
    input logic                 o_accepted,
    input logic [CNT_W-1:0]     o_added_count,
    input logic [WORD_BITS-1:0] o_out_value,
    input logic [LVL_W-1:0]     o_out_priority,
    input logic                 o_last
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) && $stable(o_out_value)
            && $stable(o_last))
        else $error("stalled result changed");

    // ack carries no word and always ends its request
    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ACK |-> o_last && o_out_value == '0 && o_out_priority == '0)
        else $error("malformed enqueue ack");

    // empty dequeue result is a single cleared result
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_EMPTY |-> o_last && !o_accepted && o_added_count == '0
            && o_out_value == '0)
        else $error("malformed empty result");

    // a dequeued word never reports enqueue fields
    a_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_WORD |-> !o_accepted && o_added_count == '0)
        else $error("dequeued word with enqueue fields");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind strict_priority_batch_queue spbq_checker #(
    .WORD_BITS (WORD_BITS),
    .LVL_W     (LVL_W)
) u_spbq_checker (.*);

>>> tb/strict_priority_batch_queue_tb.sv
// self-checking testbench for strict_priority_batch_queue: directed and random traffic
// holds its own model of the four rings and batch count in a small scoreboard class
// depends on spbq_pkg and the strict_priority_batch_queue rtl
module strict_priority_batch_queue_tb
    import spbq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int LONG_HOLD    = 100;
    localparam int SETTLE       = 20;
    localparam int RANDOM_ITEMS = 130;

    // one result transfer, as seen on the output channel
    typedef struct packed {
        logic [1:0]       kind;
        logic             accepted;
        logic [CNT_W-1:0] count;
        logic [31:0]      word;
        logic [1:0]       level;
        logic             last;
    } t_ring_result;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_ALTERNATE,
        STALL_HEAVY
    } t_stall_mode;

    // scoreboard: predicts results per accepted request and checks them in order
    class ring_scoreboard;
        logic [31:0]      slots [LEVELS_DEF][RING_SLOTS_DEF];
        int               rd_ptr [LEVELS_DEF];
        int               wr_ptr [LEVELS_DEF];
        logic [CNT_W-1:0] batch_count;
        t_ring_result     awaited_results [$];
        int               errors;

        function new();
            for (int l = 0; l < LEVELS_DEF; l++) begin
                rd_ptr[l] = 0;
                wr_ptr[l] = 0;
            end
            batch_count = '0;
            errors      = 0;
        endfunction

        function int next_slot(int p);
            return (p == RING_SLOTS_DEF - 1) ? 0 : p + 1;
        endfunction

        function void note_request(logic op, logic [1:0] prio, logic [31:0] val,
                                   logic bend, logic [2:0] maxi);
            t_ring_result r;
            int           lvl;
            int           take;
            int           avail;
            r      = '0;
            r.last = 1'b1;
            // enqueue: store unless the ring is full, then ack with the batch count
            if (op == OP_ENQ) begin
                r.kind = KIND_ACK;
                if (next_slot(wr_ptr[prio]) != rd_ptr[prio]) begin
                    slots[prio][wr_ptr[prio]] = val;
                    wr_ptr[prio] = next_slot(wr_ptr[prio]);
                    r.accepted = 1'b1;
                    if (batch_count != CNT_SAT) batch_count++;
                end
                r.count = batch_count;
                if (bend) batch_count = '0;
                awaited_results.push_back(r);
                return;
            end
            // dequeue: only the highest-priority non-empty ring is served
            take = (maxi > BATCH_MAX_DEF) ? BATCH_MAX_DEF : int'(maxi);
            lvl  = 0;
            while (lvl < LEVELS_DEF && rd_ptr[lvl] == wr_ptr[lvl]) lvl++;
            if (lvl == LEVELS_DEF || take == 0) begin
                r.kind = KIND_EMPTY;
                awaited_results.push_back(r);
                return;
            end
            avail = (wr_ptr[lvl] - rd_ptr[lvl] + RING_SLOTS_DEF) % RING_SLOTS_DEF;
            if (take > avail) take = avail;
            r.kind  = KIND_WORD;
            r.level = 2'(lvl);
            for (int n = 0; n < take; n++) begin
                r.word = slots[lvl][rd_ptr[lvl]];
                r.last = (n == take - 1);
                rd_ptr[lvl] = next_slot(rd_ptr[lvl]);
                awaited_results.push_back(r);
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(t_ring_result got);
            t_ring_result want;
            if (awaited_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %0h", $time, got);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
            compare_field("added_count", 32'(want.count), 32'(got.count));
            compare_field("out_value", want.word, got.word);
            compare_field("out_priority", 32'(want.level), 32'(got.level));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_opcode;
    logic [1:0]  i_priority_req;
    logic [31:0] i_value;
    logic        i_batch_end;
    logic [2:0]  i_take_limit;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic        o_accepted;
    logic [7:0]  o_added_count;
    logic [31:0] o_out_value;
    logic [1:0]  o_out_priority;
    logic        o_last;

    ring_scoreboard sb = new();
    int             quiet_cycles = 0;
    int             burst_left   = 0;
    int             holds_asked  = 0;
    int             holds_served = 0;

    strict_priority_batch_queue DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_priority_req (i_priority_req),
        .i_value        (i_value),
        .i_batch_end    (i_batch_end),
        .i_take_limit   (i_take_limit),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_accepted     (o_accepted),
        .o_added_count  (o_added_count),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_last         (o_last)
    );

    always #1 i_clk = ~i_clk;

    // offer one request from a falling edge and hold it until the transfer
    task automatic send_request(logic op, logic [1:0] prio, logic [31:0] val,
                                logic bend, logic [2:0] maxi);
        i_in_valid     = 1'b1;
        i_opcode       = op;
        i_priority_req = prio;
        i_value        = val;
        i_batch_end    = bend;
        i_take_limit   = maxi;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(op, prio, val, bend, maxi);
        @(negedge i_clk);
    endtask

    // sender bursts with idle gaps in between
    task automatic between_items();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 8);
        gap = $urandom_range(1, 6);
        i_in_valid = 1'b0;
        repeat (gap) @(negedge i_clk);
    endtask

    task automatic enqueue(logic [1:0] prio, logic [31:0] val, logic bend);
        send_request(OP_ENQ, prio, val, bend, 3'($urandom_range(0, 7)));
        between_items();
    endtask

    task automatic dequeue(logic [2:0] maxi);
        send_request(OP_DEQ, 2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                     maxi);
        between_items();
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.awaited_results.size() != 0) @(negedge i_clk);
    endtask

    // random traffic: enqueue-leaning mix, biased values and batch sizes
    task automatic random_item();
        logic [31:0] val;
        logic [2:0]  maxi;
        case ($urandom_range(0, 7))
            0:       val = 32'hFFFF_FFFF;
            1:       val = 32'h0;
            default: val = $urandom;
        endcase
        maxi = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                           : 3'($urandom_range(1, 4));
        if ($urandom_range(0, 99) < 55)
            enqueue(2'($urandom_range(0, 3)), val, $urandom_range(0, 3) == 0);
        else
            dequeue(maxi);
    endtask

    // receiver: long hold-off on request, otherwise a changing stall pattern
    initial begin
        int          pattern_left;
        t_stall_mode stall_mode;
        pattern_left = 0;
        stall_mode   = STALL_NONE;
        i_out_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != holds_asked) begin
                holds_served++;
                i_out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            if (pattern_left == 0) begin
                stall_mode   = t_stall_mode'($urandom_range(0, 3));
                pattern_left = $urandom_range(8, 40);
            end
            pattern_left--;
            case (stall_mode)
                STALL_NONE:      i_out_stall = 1'b0;
                STALL_LIGHT:     i_out_stall = ($urandom_range(0, 3) == 0);
                STALL_ALTERNATE: i_out_stall = (pattern_left % 3 == 0);
                default:         i_out_stall = ($urandom_range(0, 2) != 0);
            endcase
        end
    end

    // result transfers go to the scoreboard
    always @(posedge i_clk) begin
        t_ring_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind     = o_kind;
            got.accepted = o_accepted;
            got.count    = o_added_count;
            got.word     = o_out_value;
            got.level    = o_out_priority;
            got.last     = o_last;
            sb.check_result(got);
        end
    end

    // cycles without any transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("%0t: no transfer for %0d cycles, %0d results still awaited",
                 $time, QUIET_LIMIT, sb.awaited_results.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int  sent;
        bit  hold_done;
        bit  drain_done;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_ENQ;
        i_priority_req = '0;
        i_value        = '0;
        i_batch_end    = 1'b0;
        i_take_limit   = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty rings, extremes, zero and oversized batches
        dequeue(3'd4);
        enqueue(2'd3, 32'h0000_0000, 1'b0);
        enqueue(2'd0, 32'hFFFF_FFFF, 1'b0);
        enqueue(2'd1, 32'h5A5A_C3C3, 1'b1);
        dequeue(3'd0);
        dequeue(3'd7);
        // fill ring 2 past full, the refused word ends the batch
        for (int k = 0; k < 8; k++)
            enqueue(2'd2, $urandom, k == 7);
        dequeue(3'd5);
        dequeue(3'd4);
        dequeue(3'd6);
        dequeue(3'd4);
        dequeue(3'd1);

        // random part with a long receiver hold and a full drain in the middle
        sent       = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (!hold_done && sent >= RANDOM_ITEMS / 3) begin
                hold_done = 1'b1;
                holds_asked++;
            end
            if (!drain_done && sent >= 2 * RANDOM_ITEMS / 3) begin
                drain_done = 1'b1;
                wait_drained();
            end
            random_item();
            sent++;
        end

        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0t: %0d mismatches, %0d results never arrived",
                     $time, sb.errors, sb.awaited_results.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
